// File: rtl/core/bavs_pkg.sv
package bavs_pkg;

    localparam int LNT_W      = 21;   // ln t, Q5.16
    localparam int SCORE_W    = 27;   // signed score, Q18.8
    localparam int DIVD_W     = 37;   // ln t << 16
    localparam int SQX_W      = 38;   // radicand padded to an even width
    localparam int ROOT_W     = 19;
    localparam int DIV_STEPS  = 37;
    localparam int SQRT_STEPS = 19;

    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic signed [SCORE_W-1:0] UNTRIED_SCORE = 27'sd2560000;
    localparam logic signed [SCORE_W-1:0] CHAIN_FLOOR   = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [23:0] EST_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] EST_MIN = 24'sh800000;

    localparam logic [2:0] CFG_POLICY  = 3'd0;
    localparam logic [2:0] CFG_EPSILON = 3'd1;
    localparam logic [2:0] CFG_LRATE   = 3'd2;
    localparam logic [2:0] CFG_UCB_C   = 3'd3;
    localparam logic [2:0] CFG_ARMS    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_LN, S_DIV, S_SQRT, S_MUL, S_SUM, S_QLOAD, S_SCAN, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        L_IDLE, L_NORM, L_SQ, L_MUL, L_DONE
    } t_ln_state;

    typedef struct packed {
        logic upd;
        logic inc;
        logic div_load;
        logic div_step;
        logic sq_load;
        logic sq_step;
        logic mul;
        logic sum;
        logic load_q;
    } t_cell_ctl;

endpackage

// File: rtl/core/bavs_ln.sv
module bavs_ln (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [31:0]                i_t,
    output logic                       o_done,
    output logic [bavs_pkg::LNT_W-1:0] o_lnt
);
    import bavs_pkg::*;

    t_ln_state   r_state, n_state;
    logic [31:0] r_m;
    logic [4:0]  r_k;
    logic [15:0] r_frac;
    logic [3:0]  r_cnt;
    logic [63:0] sq;
    logic [36:0] scaled;

    assign sq     = r_m * r_m;
    assign scaled = {r_k, r_frac} * LN2_Q16;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE: if (i_start) n_state = (i_t <= 32'd1) ? L_DONE : L_NORM;
            L_NORM: if (r_m[31]) n_state = L_SQ;
            L_SQ:   if (r_cnt == 4'd15) n_state = L_MUL;
            L_MUL:  n_state = L_DONE;
            L_DONE: n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == L_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                r_m    <= i_t;
                r_k    <= 5'd31;
                r_frac <= '0;
                r_cnt  <= '0;
                o_lnt  <= '0;
            end
            L_NORM: begin
                if (!r_m[31]) begin
                    r_m <= {r_m[30:0], 1'b0};
                    r_k <= r_k - 5'd1;
                end
            end
            L_SQ: begin
                r_cnt <= r_cnt + 4'd1;
                if (sq[63]) begin
                    r_m    <= sq[63:32];
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_m    <= sq[62:31];
                    r_frac <= {r_frac[14:0], 1'b0};
                end
            end
            L_MUL:  o_lnt <= scaled[36:16];
            L_DONE: ;
            default: ;
        endcase
    end

endmodule

// File: rtl/core/bavs_mod.sv
module bavs_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [4:0]  i_divisor,
    output logic        o_done,
    output logic [4:0]  o_rem
);
    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [15:0] r_quo;
    logic [4:0]  r_div;
    logic [5:0]  trial;

    assign trial = {o_rem, r_quo[15]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_cnt == 4'd15);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_cnt == 4'd15) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_div <= i_divisor;
            o_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[14:0], 1'b0};
            r_cnt <= r_cnt + 4'd1;
            if (trial >= {1'b0, r_div}) begin
                o_rem <= 5'(trial - {1'b0, r_div});
            end else begin
                o_rem <= trial[4:0];
            end
        end
    end

endmodule

// File: rtl/core/bavs_cell.sv
module bavs_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bavs_pkg::t_cell_ctl                 i_ctl,
    input  logic [IW-1:0]                       i_sel,
    input  logic signed [15:0]                  i_reward,
    input  logic [15:0]                         i_lr,
    input  logic [15:0]                         i_ucb_c,
    input  logic [bavs_pkg::LNT_W-1:0]          i_lnt,
    input  logic [4:0]                          i_arms,
    input  logic signed [bavs_pkg::SCORE_W-1:0] i_in_score,
    input  logic [IW-1:0]                       i_in_idx,
    output logic signed [bavs_pkg::SCORE_W-1:0] o_best_score,
    output logic [IW-1:0]                       o_best_idx
);
    import bavs_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [23:0]         r_q;
    logic [31:0]                r_n;
    logic [31:0]                r_rem;
    logic [DIVD_W-1:0]          r_quo;
    logic [SQX_W-1:0]           r_sx;
    logic [20:0]                r_sqr;
    logic [ROOT_W-1:0]          r_root;
    logic [34:0]                r_prod;
    logic signed [SCORE_W-1:0]  r_score;

    logic                       hit;
    logic                       active;
    logic signed [24:0]         diff;
    logic signed [41:0]         prod;
    logic signed [25:0]         delta;
    logic signed [26:0]         nq;
    logic [32:0]                dtrial;
    logic [22:0]                strial;
    logic [22:0]                sbase;

    assign hit    = (i_sel == MY_IDX);
    assign active = (int'(i_arms) > IDX);
    assign diff   = 25'(i_reward) - 25'(r_q);
    assign prod   = diff * $signed({1'b0, i_lr});
    assign delta  = 26'(prod >>> 16);
    assign nq     = 27'(r_q) + 27'(delta);
    assign dtrial = {r_rem, r_quo[DIVD_W-1]};
    assign strial = {r_sqr, r_sx[SQX_W-1 -: 2]};
    assign sbase  = 23'({r_root, 2'b01});

    // estimate and pull count of this arm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
            r_n <= '0;
        end else begin
            if (i_ctl.upd && hit) begin
                if (nq > 27'(EST_MAX)) begin
                    r_q <= EST_MAX;
                end else if (nq < 27'(EST_MIN)) begin
                    r_q <= EST_MIN;
                end else begin
                    r_q <= nq[23:0];
                end
            end
            if (i_ctl.inc && hit && (r_n != 32'hFFFF_FFFF)) begin
                r_n <= r_n + 32'd1;
            end
        end
    end

    // bonus: shift-subtract divide, digit-by-digit root, times c; then score
    always_ff @(posedge i_clk) begin
        if (i_ctl.div_load) begin
            r_rem <= '0;
            r_quo <= {i_lnt, 16'b0};
        end else if (i_ctl.div_step) begin
            r_quo <= {r_quo[DIVD_W-2:0], dtrial >= {1'b0, r_n}};
            if (dtrial >= {1'b0, r_n}) begin
                r_rem <= 32'(dtrial - {1'b0, r_n});
            end else begin
                r_rem <= dtrial[31:0];
            end
        end
        if (i_ctl.sq_load) begin
            r_sx   <= {1'b0, r_quo};
            r_sqr  <= '0;
            r_root <= '0;
        end else if (i_ctl.sq_step) begin
            r_sx <= {r_sx[SQX_W-3:0], 2'b00};
            if (strial >= sbase) begin
                r_sqr  <= 21'(strial - sbase);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_sqr  <= strial[20:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_ctl.mul) begin
            r_prod <= r_root * i_ucb_c;
        end
        if (i_ctl.sum) begin
            if (r_n == 32'd0) begin
                r_score <= UNTRIED_SCORE;
            end else begin
                r_score <= 27'(r_q) + $signed({12'b0, r_prod[34:20]});
            end
        end else if (i_ctl.load_q) begin
            r_score <= 27'(r_q);
        end
    end

    // argmax link: keep the incoming best unless an active arm strictly beats it
    always_ff @(posedge i_clk) begin
        if (active && (r_score > i_in_score)) begin
            o_best_score <= r_score;
            o_best_idx   <= MY_IDX;
        end else begin
            o_best_score <= i_in_score;
            o_best_idx   <= i_in_idx;
        end
    end

endmodule

// File: rtl/core/bandit_action_value_selector_unit.sv
// Update beats: accepted while idle, estimate written at the accepting edge, no result.
// Select beats: epsilon exploration draws the arm with a bit-serial modulo; greedy lets the
// argmax ripple down the cell row; UCB runs the ln t unit (normalise steps and 16 squarings),
// then the per-cell 37-step divide and 19-step root. One beat in flight; s_tready returns
// at the edge at which the result enters the output register.
// Reset (synchronous, active low) clears estimates, pull counts and control, sets configuration defaults.
module bandit_action_value_selector_unit #(
    parameter int MAX_ARMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // arm[3:0], reward[19:4], rand_draw[35:20], rand_arm[51:36], time_step[83:52]
    input  logic [87:0] s_tdata,
    // mode[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // action[3:0]
    output logic [7:0]  m_tdata
);
    import bavs_pkg::*;

    localparam int IW = (MAX_ARMS > 2) ? $clog2(MAX_ARMS) : 1;
    localparam int AW = (IW > 5) ? IW : 5;
    localparam int CMAX = (MAX_ARMS > DIV_STEPS) ? MAX_ARMS : DIV_STEPS;
    localparam int CW = $clog2(CMAX + 1);

    // configuration
    logic        r_policy;
    logic [15:0] r_epsilon;
    logic [15:0] r_lr;
    logic [15:0] r_ucb_c;
    logic [4:0]  r_arms;

    t_state      r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_action;
    logic        r_out_valid;
    logic [3:0]  r_out_act;

    logic        in_acc;
    logic        sel_item;
    logic        explore;
    logic        arm_ok;
    logic [4:0]  arms_eff;
    logic [AW-1:0] arm_ext;
    logic [AW-1:0] mod_ext;
    logic [AW-1:0] act_ext;
    logic [IW-1:0] sel_idx;
    logic        out_free;
    t_cell_ctl   ctl;
    logic        ln_start, ln_done;
    logic [LNT_W-1:0] lnt;
    logic        mod_start, mod_done;
    logic [4:0]  mod_rem;

    logic signed [SCORE_W-1:0] chain_score [0:MAX_ARMS];
    logic [IW-1:0]             chain_idx   [0:MAX_ARMS];

    assign in_acc   = s_tvalid && s_tready;
    assign sel_item = !s_tuser;
    assign explore  = s_tdata[35:20] < r_epsilon;
    assign arm_ok   = int'(s_tdata[3:0]) < MAX_ARMS;
    assign arm_ext  = AW'(s_tdata[3:0]);
    assign mod_ext  = AW'(mod_rem);
    assign act_ext  = AW'(r_action);
    assign out_free = !r_out_valid || m_tready;
    assign sel_idx  = (r_state == S_DONE) ? r_action : arm_ext[IW-1:0];

    // arm count clamped to 1..MAX_ARMS
    always_comb begin
        if (r_arms == 5'd0) begin
            arms_eff = 5'd1;
        end else if (int'(r_arms) > MAX_ARMS) begin
            arms_eff = 5'(MAX_ARMS);
        end else begin
            arms_eff = r_arms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= 1'b0;
            r_epsilon <= 16'd6554;
            r_lr      <= 16'd6554;
            r_ucb_c   <= 16'd8192;
            r_arms    <= 5'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLICY:  r_policy  <= i_cfg_data[0];
                CFG_EPSILON: r_epsilon <= i_cfg_data;
                CFG_LRATE:   r_lr      <= i_cfg_data;
                CFG_UCB_C:   r_ucb_c   <= i_cfg_data;
                CFG_ARMS:    r_arms    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && sel_item) begin
                    if (r_policy) begin
                        n_state = S_LN;
                    end else if (explore) begin
                        n_state = S_MOD;
                    end else begin
                        n_state = S_QLOAD;
                    end
                end
            end
            S_MOD:   if (mod_done) n_state = S_DONE;
            S_LN:    if (ln_done) n_state = S_DIV;
            S_DIV:   if (r_cnt == CW'(DIV_STEPS)) n_state = S_SQRT;
            S_SQRT:  if (r_cnt == CW'(SQRT_STEPS)) n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_SCAN;
            S_QLOAD: n_state = S_SCAN;
            S_SCAN:  if (r_cnt == CW'(MAX_ARMS)) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        ctl       = '0;
        s_tready  = (r_state == S_IDLE);
        ln_start  = in_acc && sel_item && r_policy;
        mod_start = in_acc && sel_item && !r_policy && explore;
        ctl.upd   = in_acc && !sel_item && arm_ok;
        unique case (r_state)
            S_DIV: begin
                ctl.div_load = (r_cnt == '0);
                ctl.div_step = (r_cnt != '0);
            end
            S_SQRT: begin
                ctl.sq_load = (r_cnt == '0);
                ctl.sq_step = (r_cnt != '0);
            end
            S_MUL:   ctl.mul    = 1'b1;
            S_SUM:   ctl.sum    = 1'b1;
            S_QLOAD: ctl.load_q = 1'b1;
            S_DONE:  ctl.inc    = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MOD && mod_done) begin
            r_action <= mod_ext[IW-1:0];
        end else if (r_state == S_SCAN && r_cnt == CW'(MAX_ARMS)) begin
            r_action <= chain_idx[MAX_ARMS];
        end
        if (r_state == S_DONE && out_free) begin
            r_out_act <= act_ext[3:0];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0, r_out_act};

    bavs_ln u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ln_start),
        .i_t     (s_tdata[83:52]),
        .o_done  (ln_done),
        .o_lnt   (lnt)
    );

    bavs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (s_tdata[51:36]),
        .i_divisor  (arms_eff),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // row of arm cells; the running best enters at the floor score
    assign chain_score[0] = CHAIN_FLOOR;
    assign chain_idx[0]   = '0;

    for (genvar g = 0; g < MAX_ARMS; g++) begin : g_cell
        bavs_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_sel        (sel_idx),
            .i_reward     ($signed(s_tdata[19:4])),
            .i_lr         (r_lr),
            .i_ucb_c      (r_ucb_c),
            .i_lnt        (lnt),
            .i_arms       (arms_eff),
            .i_in_score   (chain_score[g]),
            .i_in_idx     (chain_idx[g]),
            .o_best_score (chain_score[g+1]),
            .o_best_idx   (chain_idx[g+1])
        );
    end

    // a select beat always takes the input side away in the following cycle
    a_select_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && sel_item) |=> !s_tready)
        else $error("input still open after a select beat");

    // the log unit only finishes while the sequencer waits for it
    a_ln_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ln_done |-> (r_state == S_LN))
        else $error("ln result outside its wait state");

    // leaving the final state always leaves a result behind
    a_done_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> m_tvalid)
        else $error("select finished without an output beat");

endmodule
